@@ design/motion_schedule_light_fader_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the motion/schedule light fader
// Implication checks on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef MOTION_SCHEDULE_LIGHT_FADER_MACROS_SVH
`define MOTION_SCHEDULE_LIGHT_FADER_MACROS_SVH

`ifndef NO_ASSERTIONS

// pre holds -> post holds in the same cycle
`define MSLF_ASSERT_IMPLY(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// pre holds -> post holds in the next cycle
`define MSLF_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`else

`define MSLF_ASSERT_IMPLY(label, pre, post, msg)
`define MSLF_ASSERT_NEXT(label, pre, post, msg)

`endif

`endif

@@ design/mslf_pkg.sv @@
// ----------------------------------------------------------------------------
// mslf_pkg
// Item types, codes and mode helpers for the light fader.
// ----------------------------------------------------------------------------
package mslf_pkg;

    localparam int MODE_W  = 42;
    localparam int LEN_W   = 16;
    localparam int CH_N    = 5;
    localparam int CH_W    = 3;
    localparam int COLOR_EN_BIT = 40;
    localparam int WHITE_EN_BIT = 41;

    typedef logic [MODE_W-1:0] mode_t;

    // action codes
    localparam logic [1:0] ACT_TICK     = 2'd0;
    localparam logic [1:0] ACT_MOTION   = 2'd1;
    localparam logic [1:0] ACT_SCHEDULE = 2'd2;
    localparam logic [1:0] ACT_START    = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_LOW_MODE    = 2'd0;
    localparam logic [1:0] CFG_HIGH_MODE   = 2'd1;
    localparam logic [1:0] CFG_FADE_ON_MS  = 2'd2;
    localparam logic [1:0] CFG_FADE_OFF_MS = 2'd3;

    // channel order of the serial blend
    localparam logic [CH_W-1:0] CH_BRIGHT = 3'd0;
    localparam logic [CH_W-1:0] CH_GREEN  = 3'd1;
    localparam logic [CH_W-1:0] CH_RED    = 3'd2;
    localparam logic [CH_W-1:0] CH_BLUE   = 3'd3;
    localparam logic [CH_W-1:0] CH_WHITE  = 3'd4;

    typedef struct packed {
        logic [1:0] action;
        logic       level;
    } in_item_t;

    typedef struct packed {
        logic [7:0] brightness;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] blue;
        logic [7:0] white;
        logic       fading;
    } out_item_t;

    // byte of a packed mode for one channel
    function automatic logic [7:0] mode_byte(input mode_t m, input logic [CH_W-1:0] ch);
        logic [7:0] b;
        unique case (ch)
            CH_BRIGHT: b = m[7:0];
            CH_GREEN:  b = m[23:16];
            CH_RED:    b = m[31:24];
            CH_BLUE:   b = m[15:8];
            CH_WHITE:  b = m[39:32];
            default:   b = 8'h00;
        endcase
        return b;
    endfunction

    // channels shown for a mode; colour and white gated by their enables
    function automatic out_item_t mode_show(input mode_t m, input logic fading);
        out_item_t o;
        o.brightness = m[7:0];
        o.green      = m[COLOR_EN_BIT] ? m[23:16] : 8'h00;
        o.red        = m[COLOR_EN_BIT] ? m[31:24] : 8'h00;
        o.blue       = m[COLOR_EN_BIT] ? m[15:8]  : 8'h00;
        o.white      = m[WHITE_EN_BIT] ? m[39:32] : 8'h00;
        o.fading     = fading;
        return o;
    endfunction

endpackage

@@ design/motion_schedule_light_fader.sv @@
// ----------------------------------------------------------------------------
// motion_schedule_light_fader
// RGBW strip fader: holds a lighting mode and fades between modes on motion
// and schedule items, advancing one step per millisecond tick item.
// ----------------------------------------------------------------------------
//
//  port group   dir  handshake               payload
//  s_*          in   s_valid / s_ready       mslf_pkg::in_item_t  (action, level)
//  m_*          out  m_valid / m_ready       mslf_pkg::out_item_t (colours, fading)
//  cfg_*        in   cfg_wr_en (no wait)     cfg_index, cfg_data
//
//  An item that leaves no fade running goes from the accept edge to ST_DONE and
//  fills the output register from there once m_ready allows. An item shown
//  mid-fade runs five channels, each a load step, a bit-serial multiply and a
//  bit-serial restoring division, then loads the output register in ST_DONE.
//  s_ready rises at the edge that loads the output register.
//  Reset is synchronous, active low; it clears all mode, fade and config state.
//  The output register holds one finished item; a stalled m_ready holds the
//  next result in the blend registers and keeps s_ready low until it drains.
//
`include "motion_schedule_light_fader_macros.svh"

module motion_schedule_light_fader (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  mslf_pkg::in_item_t    s_data,

    output logic                  m_valid,
    input  logic                  m_ready,
    output mslf_pkg::out_item_t   m_data,

    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_index,
    input  logic [mslf_pkg::MODE_W-1:0] cfg_data
);

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    localparam int ACC_W = 8 + mslf_pkg::LEN_W;

    // configuration
    mslf_pkg::mode_t               low_mode_reg;
    mslf_pkg::mode_t               high_mode_reg;
    logic [mslf_pkg::LEN_W-1:0]    fade_on_reg;
    logic [mslf_pkg::LEN_W-1:0]    fade_off_reg;

    // fader state
    mslf_pkg::mode_t               current_mode_reg, current_mode_next;
    mslf_pkg::mode_t               fade_start_reg,   fade_start_next;
    mslf_pkg::mode_t               fade_target_reg,  fade_target_next;
    logic [mslf_pkg::LEN_W-1:0]    elapsed_reg,      elapsed_next;
    logic [mslf_pkg::LEN_W-1:0]    fade_len_reg,     fade_len_next;
    logic                          fade_active_reg,  fade_active_next;

    // serial blend datapath
    logic [2:0]                    state_reg, state_next;
    logic [mslf_pkg::CH_W-1:0]     ch_reg, ch_next;
    logic [2:0]                    step_reg, step_next;
    logic [7:0]                    sbits_reg, sbits_next;
    logic [7:0]                    tbits_reg, tbits_next;
    logic [ACC_W-1:0]              acc_reg, acc_next;
    logic [7:0]                    res_reg [mslf_pkg::CH_N];

    // output register
    logic                          m_valid_reg;
    mslf_pkg::out_item_t           m_data_reg;

    logic                          s_accept;
    logic                          out_load;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    // ------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_mode_reg  <= '0;
            high_mode_reg <= '0;
            fade_on_reg   <= '0;
            fade_off_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                mslf_pkg::CFG_LOW_MODE:    low_mode_reg  <= cfg_data;
                mslf_pkg::CFG_HIGH_MODE:   high_mode_reg <= cfg_data;
                mslf_pkg::CFG_FADE_ON_MS:  fade_on_reg   <= cfg_data[mslf_pkg::LEN_W-1:0];
                mslf_pkg::CFG_FADE_OFF_MS: fade_off_reg  <= cfg_data[mslf_pkg::LEN_W-1:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Item decode: mode and fade state update at the accept edge
    // ------------------------------------------------------------------
    logic                          go_fade;
    mslf_pkg::mode_t               go_target;
    logic [mslf_pkg::LEN_W-1:0]    go_len;
    logic [mslf_pkg::LEN_W-1:0]    tick_count;

    assign tick_count = elapsed_reg + 1'b1;

    always_comb begin
        current_mode_next = current_mode_reg;
        fade_start_next   = fade_start_reg;
        fade_target_next  = fade_target_reg;
        elapsed_next      = elapsed_reg;
        fade_len_next     = fade_len_reg;
        fade_active_next  = fade_active_reg;
        go_fade           = 1'b0;
        go_target         = '0;
        go_len            = fade_on_reg;

        if (s_accept) begin
            if (fade_active_reg) begin
                // only ticks count during a fade; other items are dropped
                if (s_data.action == mslf_pkg::ACT_TICK) begin
                    elapsed_next = tick_count;
                    if (tick_count >= fade_len_reg) begin
                        current_mode_next = fade_target_reg;
                        fade_active_next  = 1'b0;
                    end
                end
            end else begin
                unique case (s_data.action)
                    mslf_pkg::ACT_START: begin
                        current_mode_next = low_mode_reg;
                    end
                    mslf_pkg::ACT_MOTION: begin
                        // skip when brightness, colour and white already match
                        if (s_data.level && (current_mode_reg[39:0] != high_mode_reg[39:0])) begin
                            go_fade   = 1'b1;
                            go_target = high_mode_reg;
                            go_len    = fade_on_reg;
                        end
                    end
                    mslf_pkg::ACT_SCHEDULE: begin
                        if (s_data.level && (current_mode_reg[7:0] == 8'h00)) begin
                            go_fade   = 1'b1;
                            go_target = low_mode_reg;
                            go_len    = fade_on_reg;
                        end else if (!s_data.level && (current_mode_reg[7:0] != 8'h00)) begin
                            go_fade   = 1'b1;
                            go_target = '0;
                            go_len    = fade_off_reg;
                        end
                    end
                    mslf_pkg::ACT_TICK: begin
                        // idle tick: hold everything
                    end
                endcase

                if (go_fade) begin
                    if (go_len == '0) begin
                        // zero length: jump straight to the target
                        current_mode_next = go_target;
                    end else begin
                        fade_start_next  = current_mode_reg;
                        fade_target_next = go_target;
                        fade_len_next    = go_len;
                        elapsed_next     = '0;
                        fade_active_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            current_mode_reg <= '0;
            fade_start_reg   <= '0;
            fade_target_reg  <= '0;
            elapsed_reg      <= '0;
            fade_len_reg     <= '0;
            fade_active_reg  <= 1'b0;
        end else begin
            current_mode_reg <= current_mode_next;
            fade_start_reg   <= fade_start_next;
            fade_target_reg  <= fade_target_next;
            elapsed_reg      <= elapsed_next;
            fade_len_reg     <= fade_len_next;
            fade_active_reg  <= fade_active_next;
        end
    end

    // ------------------------------------------------------------------
    // Serial blend: per channel, num = s*(D-e) + t*e one bit of s and t per
    // cycle (MSB first), then num / D one quotient bit per cycle. The
    // remainder lives in acc[23:8]; quotient bits shift in at acc[0].
    // ------------------------------------------------------------------
    logic [mslf_pkg::LEN_W-1:0]    remain_len;
    logic [ACC_W-1:0]              mul_sum;
    logic [mslf_pkg::LEN_W:0]      trial;
    logic [mslf_pkg::LEN_W-1:0]    trial_diff;
    logic                          q_bit;
    logic [mslf_pkg::LEN_W-1:0]    rem_new;

    assign remain_len = fade_len_reg - elapsed_reg;
    assign mul_sum    = {acc_reg[ACC_W-2:0], 1'b0}
                      + (sbits_reg[7] ? ACC_W'(remain_len) : '0)
                      + (tbits_reg[7] ? ACC_W'(elapsed_reg) : '0);
    assign trial      = {acc_reg[ACC_W-1:8], acc_reg[7]};
    // trial stays below 2*D, so the low bits of the difference are exact
    assign trial_diff = trial[mslf_pkg::LEN_W-1:0] - fade_len_reg;
    assign q_bit      = (trial >= {1'b0, fade_len_reg});
    assign rem_new    = q_bit ? trial_diff : trial[mslf_pkg::LEN_W-1:0];

    always_comb begin
        state_next = state_reg;
        ch_next    = ch_reg;
        step_next  = step_reg;
        sbits_next = sbits_reg;
        tbits_next = tbits_reg;
        acc_next   = acc_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    ch_next    = mslf_pkg::CH_BRIGHT;
                    state_next = fade_active_next ? ST_LOAD : ST_DONE;
                end
            end
            ST_LOAD: begin
                sbits_next = mslf_pkg::mode_byte(fade_start_reg, ch_reg);
                tbits_next = mslf_pkg::mode_byte(fade_target_reg, ch_reg);
                acc_next   = '0;
                step_next  = '0;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                acc_next   = mul_sum;
                sbits_next = {sbits_reg[6:0], 1'b0};
                tbits_next = {tbits_reg[6:0], 1'b0};
                step_next  = step_reg + 1'b1;
                if (step_reg == 3'd7) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                acc_next  = {rem_new, acc_reg[6:0], q_bit};
                step_next = step_reg + 1'b1;
                if (step_reg == 3'd7) begin
                    if (ch_reg == mslf_pkg::CH_WHITE) begin
                        state_next = ST_DONE;
                    end else begin
                        ch_next    = ch_reg + 1'b1;
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ch_reg    <= '0;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        sbits_reg <= sbits_next;
        tbits_reg <= tbits_next;
        acc_reg   <= acc_next;
        if ((state_reg == ST_DIV) && (step_reg == 3'd7)) begin
            res_reg[ch_reg] <= acc_next[7:0];
        end
    end

    // ------------------------------------------------------------------
    // Result assembly: blended mode while fading, else the current mode.
    // Colour blends only when both ends have colour on; otherwise take the
    // target's colour and enable. White enable always follows the target.
    // ------------------------------------------------------------------
    mslf_pkg::mode_t               blend_mode;
    logic                          both_color;

    assign both_color = fade_start_reg[mslf_pkg::COLOR_EN_BIT]
                     && fade_target_reg[mslf_pkg::COLOR_EN_BIT];

    always_comb begin
        blend_mode        = '0;
        blend_mode[7:0]   = res_reg[mslf_pkg::CH_BRIGHT];
        blend_mode[39:32] = res_reg[mslf_pkg::CH_WHITE];
        if (both_color) begin
            blend_mode[15:8]  = res_reg[mslf_pkg::CH_BLUE];
            blend_mode[23:16] = res_reg[mslf_pkg::CH_GREEN];
            blend_mode[31:24] = res_reg[mslf_pkg::CH_RED];
        end else begin
            blend_mode[31:8]  = fade_target_reg[31:8];
        end
        blend_mode[mslf_pkg::COLOR_EN_BIT] = fade_target_reg[mslf_pkg::COLOR_EN_BIT];
        blend_mode[mslf_pkg::WHITE_EN_BIT] = fade_target_reg[mslf_pkg::WHITE_EN_BIT];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= fade_active_reg ? mslf_pkg::mode_show(blend_mode, 1'b1)
                                          : mslf_pkg::mode_show(current_mode_reg, 1'b0);
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `MSLF_ASSERT_IMPLY(a_fade_in_range, fade_active_reg, elapsed_reg < fade_len_reg, "tick count at fade length")
    `MSLF_ASSERT_IMPLY(a_div_rem_below_len, state_reg == ST_DIV, acc_reg[ACC_W-1:8] < fade_len_reg, "remainder too big")
    `MSLF_ASSERT_NEXT(a_mode_held_busy, state_reg != ST_IDLE, $stable(current_mode_reg) && $stable(elapsed_reg), "state moved")
    `MSLF_ASSERT_IMPLY(a_out_from_done, $rose(m_valid_reg), $past(state_reg == ST_DONE), "output loaded outside done")
    `MSLF_ASSERT_IMPLY(a_channel_range, state_reg != ST_IDLE, ch_reg <= mslf_pkg::CH_WHITE, "channel out of range")

endmodule
